// ===== sv/zeu_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// zeu_pkg
// Shared types, codes and saturating arithmetic helpers of the zone energy
// update core.
// ----------------------------------------------------------------------------
package zeu_pkg;

    localparam int DEF_MAX_ZONES   = 64;
    localparam int ZONE_SLOT_LIMIT = 64;

    localparam logic [1:0] CMD_TERM  = 2'd0;
    localparam logic [1:0] CMD_ZONE  = 2'd1;
    localparam logic [1:0] CMD_MAT   = 2'd2;
    localparam logic [1:0] CMD_CLEAR = 2'd3;

    localparam logic [1:0] REG_TIME_STEP    = 2'd0;
    localparam logic [1:0] REG_STAGE_SELECT = 2'd1;
    localparam logic [1:0] REG_ZONE_COUNT   = 2'd2;

    localparam logic [1:0] STS_NORMAL   = 2'd0;
    localparam logic [1:0] STS_FALLBACK = 2'd1;
    localparam logic [1:0] STS_NONPOS   = 2'd2;

    localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;
    localparam logic signed [63:0] S32_MAX_X = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] S32_MIN_X = 64'shFFFF_FFFF_8000_0000;

    typedef struct packed {
        logic        [1:0]  cmd;
        logic        [5:0]  row_zone;
        logic        [5:0]  col_zone;
        logic signed [31:0] value_a;
        logic signed [31:0] value_b;
        logic signed [31:0] value_c;
        logic signed [31:0] value_d;
    } t_in;

    typedef struct packed {
        logic        [5:0]  zone_index;
        logic signed [31:0] new_energy;
        logic        [1:0]  energy_status;
    } t_out;

    typedef enum logic [2:0] {
        KIND_TERM,
        KIND_ZONE,
        KIND_MAT,
        KIND_MAT_LAST,
        KIND_CLEAR
    } t_kind;

    typedef struct packed {
        t_kind kind;
        t_in   item;
    } t_job;

    typedef struct packed {
        logic               start;
        logic signed [63:0] x;
        logic signed [31:0] m;
    } t_mul_req;

    typedef struct packed {
        logic               start;
        logic signed [63:0] t;
        logic signed [31:0] m;
    } t_div_req;

    function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            return s[64] ? S64_MIN : S64_MAX;
        end
        return s[63:0];
    endfunction

    // Applies a sign to an unsigned magnitude and saturates to 64 bits.
    function automatic logic signed [63:0] signed_sat64(input logic [63:0] r,
                                                        input logic neg);
        if (!neg) begin
            return r[63] ? S64_MAX : $signed(r);
        end
        if (r[63]) begin
            return S64_MIN;
        end
        return -$signed(r);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] e);
        if (e > S32_MAX_X) begin
            return 32'sh7FFF_FFFF;
        end
        if (e < S32_MIN_X) begin
            return 32'sh8000_0000;
        end
        return e[31:0];
    endfunction

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        return v[31] ? 32'(-v) : 32'(v);
    endfunction

endpackage
`default_nettype wire

// ===== sv/zone_energy_update_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// zone_energy_update_core
// Zone internal-energy update in Q16.16 with saturating 64-bit sums.
//
//   Channel   Handshake           Payload      Direction
//   input     i_valid / o_ready   i_data       in
//   output    o_valid / i_ready   o_data       out
//   config    i_cfg_we            i_cfg_idx,   in
//                                 i_cfg_data
//
// A force term, zone data, clear and matrix entries each take their own
// path through the execution states; the last column of a row adds the
// energy update, which waits until the output register is free.
// The fallback path adds a multiply and the one-bit-per-cycle divider,
// whose run is skipped when the lumped mass is zero.
// A two-entry queue keeps input transactions flowing while the execution
// side works or waits for the output register to be taken.
// Synchronous reset invalidates all work sums and clears the row accumulator at once.
// ----------------------------------------------------------------------------
module zone_energy_update_core import zeu_pkg::*; #(
    parameter int MAX_ZONES = DEF_MAX_ZONES
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire t_in         i_data,
    output logic             o_valid,
    input  wire logic        i_ready,
    output t_out             o_data,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [30:0] i_cfg_data
);

    localparam int SLOTS = (MAX_ZONES < ZONE_SLOT_LIMIT) ? MAX_ZONES : ZONE_SLOT_LIMIT;
    localparam logic [6:0] SLOTS_W = 7'(SLOTS);

    logic [30:0] r_time_step;
    logic        r_stage_select;
    logic [6:0]  r_zone_count;
    logic [6:0]  active, last_col;
    logic        job_vld, job_pop;
    t_job        job;

    always_comb begin
        if (r_zone_count == 7'd0) begin
            active = 7'd1;
        end else if (r_zone_count > SLOTS_W) begin
            active = SLOTS_W;
        end else begin
            active = r_zone_count;
        end
        last_col = active - 7'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_step    <= 31'd0;
            r_stage_select <= 1'b0;
            r_zone_count   <= 7'd64;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_TIME_STEP:    r_time_step    <= i_cfg_data;
                REG_STAGE_SELECT: r_stage_select <= i_cfg_data[0];
                REG_ZONE_COUNT:   r_zone_count   <= i_cfg_data[6:0];
                default:          ;
            endcase
        end
    end

    zeu_front #(.MAX_ZONES(MAX_ZONES)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_data     (i_data),
        .i_last_col (last_col),
        .o_job_vld  (job_vld),
        .o_job      (job),
        .i_job_pop  (job_pop)
    );

    zeu_back #(.MAX_ZONES(MAX_ZONES)) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job_vld      (job_vld),
        .i_job          (job),
        .o_job_pop      (job_pop),
        .i_time_step    (r_time_step),
        .i_stage_select (r_stage_select),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_data         (o_data)
    );

    // A normal update is only reported for a positive energy.
    a_normal_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.energy_status == STS_NORMAL) |-> (o_data.new_energy > 32'sd0))
        else $error("normal status with nonpositive energy");

    // The fallback status must agree with the sign of the reported energy.
    a_fb_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.energy_status == STS_FALLBACK) |-> (o_data.new_energy > 32'sd0))
        else $error("fallback status with nonpositive energy");

    a_nonpos_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.energy_status == STS_NONPOS) |-> (o_data.new_energy <= 32'sd0))
        else $error("nonpositive status with positive energy");

    // No result may appear in the cycle after reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

endmodule
`default_nettype wire

// ===== sv/zeu_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// zeu_front
// Accepts input transactions, classifies them and holds them in a two-entry
// queue for the execution side. Items that cannot have an effect are dropped.
// ----------------------------------------------------------------------------
module zeu_front import zeu_pkg::*; #(
    parameter int MAX_ZONES = DEF_MAX_ZONES
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire t_in        i_data,
    input  wire logic [6:0] i_last_col,
    output logic            o_job_vld,
    output t_job            o_job,
    input  wire logic       i_job_pop
);

    localparam int SLOTS = (MAX_ZONES < ZONE_SLOT_LIMIT) ? MAX_ZONES : ZONE_SLOT_LIMIT;
    localparam logic [6:0] SLOTS_W = 7'(SLOTS);

    t_job       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt, n_cnt;
    t_job       job_in;
    logic       keep, push;

    always_comb begin
        job_in.item = i_data;
        job_in.kind = KIND_TERM;
        keep        = 1'b1;
        if (i_data.cmd == CMD_CLEAR) begin
            job_in.kind = KIND_CLEAR;
        end else if ({1'b0, i_data.row_zone} >= SLOTS_W) begin
            keep = 1'b0;
        end else begin
            case (i_data.cmd)
                CMD_TERM: job_in.kind = KIND_TERM;
                CMD_ZONE: job_in.kind = KIND_ZONE;
                CMD_MAT: begin
                    if ({1'b0, i_data.col_zone} > i_last_col) begin
                        keep = 1'b0;
                    end else if ({1'b0, i_data.col_zone} == i_last_col) begin
                        job_in.kind = KIND_MAT_LAST;
                    end else begin
                        job_in.kind = KIND_MAT;
                    end
                end
                default: keep = 1'b0;
            endcase
        end
    end

    assign o_ready   = (r_cnt != 2'd2);
    assign push      = i_valid && o_ready && keep;
    assign o_job_vld = (r_cnt != 2'd0);
    assign o_job     = r_q[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (push && !i_job_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!push && i_job_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_job_pop) begin
                r_rp <= ~r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= job_in;
        end
    end

endmodule
`default_nettype wire

// ===== sv/zeu_mulq.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// zeu_mulq
// Saturating Q16.16 multiply of a 64-bit value by a 32-bit value, truncated
// toward zero. Two 32x32 partial products are formed on one multiplier.
// ----------------------------------------------------------------------------
module zeu_mulq import zeu_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_mul_req i_req,
    output logic          o_done,
    output logic signed [63:0] o_res
);

    typedef enum logic [4:0] {
        M_IDLE = 5'b00001,
        M_LO   = 5'b00010,
        M_HI   = 5'b00100,
        M_FIN  = 5'b01000,
        M_DONE = 5'b10000
    } t_mstate;

    t_mstate r_state, n_state;
    logic [63:0] r_xm;
    logic [31:0] r_mm;
    logic        r_neg;
    logic [63:0] r_p, r_q;
    logic signed [63:0] r_res;
    logic [63:0] prod;
    logic [63:0] sum;

    assign prod   = 64'(r_mm) * 64'((r_state == M_LO) ? r_xm[31:0] : r_xm[63:32]);
    assign sum    = {r_q[47:0], 16'b0} + {16'b0, r_p[63:16]};
    assign o_done = (r_state == M_DONE);
    assign o_res  = r_res;

    always_comb begin
        n_state = r_state;
        case (r_state)
            M_IDLE, M_DONE: n_state = i_req.start ? M_LO : M_IDLE;
            M_LO:           n_state = M_HI;
            M_HI:           n_state = M_FIN;
            M_FIN:          n_state = M_DONE;
            default:        n_state = M_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == M_IDLE || r_state == M_DONE) && i_req.start) begin
            r_xm  <= mag64(i_req.x);
            r_mm  <= mag32(i_req.m);
            r_neg <= i_req.x[63] ^ i_req.m[31];
        end
        if (r_state == M_LO) begin
            r_p <= prod;
        end
        if (r_state == M_HI) begin
            r_q <= prod;
        end
        if (r_state == M_FIN) begin
            // A high partial product at or above 2^47 overflows after the shift.
            if (r_q[63:47] != '0) begin
                r_res <= r_neg ? S64_MIN : S64_MAX;
            end else begin
                r_res <= signed_sat64(sum, r_neg);
            end
        end
    end

endmodule
`default_nettype wire

// ===== sv/zeu_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// zeu_div
// Saturating Q16.16 divide t*2^16/m truncated toward zero. Restoring
// division, one quotient bit per cycle over the 80-bit scaled dividend.
// ----------------------------------------------------------------------------
module zeu_div import zeu_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output logic          o_done,
    output logic signed [63:0] o_res
);

    localparam int DIV_BITS = 80;

    typedef enum logic [3:0] {
        D_IDLE = 4'b0001,
        D_RUN  = 4'b0010,
        D_FIN  = 4'b0100,
        D_DONE = 4'b1000
    } t_dstate;

    t_dstate r_state, n_state;
    logic [DIV_BITS-1:0] r_dvd;
    logic [31:0] r_rem, r_mm;
    logic        r_neg;
    logic [6:0]  r_cnt;
    logic signed [63:0] r_res;
    logic [32:0] rem_sh;
    logic [33:0] diff;
    logic        ge, start_ok, zero_div;

    assign rem_sh   = {r_rem, r_dvd[DIV_BITS-1]};
    assign diff     = {1'b0, rem_sh} - {2'b0, r_mm};
    assign ge       = !diff[33];
    assign start_ok = (r_state == D_IDLE || r_state == D_DONE) && i_req.start;
    assign zero_div = (i_req.m == 32'sd0);
    assign o_done   = (r_state == D_DONE);
    assign o_res    = r_res;

    always_comb begin
        n_state = r_state;
        case (r_state)
            D_IDLE, D_DONE: begin
                if (!i_req.start) begin
                    n_state = D_IDLE;
                end else begin
                    n_state = zero_div ? D_DONE : D_RUN;
                end
            end
            D_RUN:   n_state = (r_cnt == 7'(DIV_BITS - 1)) ? D_FIN : D_RUN;
            D_FIN:   n_state = D_DONE;
            default: n_state = D_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_cnt   <= 7'd0;
        end else begin
            r_state <= n_state;
            if (start_ok) begin
                r_cnt <= 7'd0;
            end else if (r_state == D_RUN) begin
                r_cnt <= r_cnt + 7'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start_ok) begin
            r_dvd <= {mag64(i_req.t), 16'b0};
            r_rem <= 32'd0;
            r_mm  <= mag32(i_req.m);
            r_neg <= i_req.t[63] ^ i_req.m[31];
            // A zero mass yields the saturated sign of t, or zero.
            if (zero_div) begin
                if (i_req.t == 64'sd0) begin
                    r_res <= 64'sd0;
                end else begin
                    r_res <= i_req.t[63] ? S64_MIN : S64_MAX;
                end
            end
        end else if (r_state == D_RUN) begin
            r_rem <= ge ? diff[31:0] : rem_sh[31:0];
            r_dvd <= {r_dvd[DIV_BITS-2:0], ge};
        end else if (r_state == D_FIN) begin
            if (r_dvd[DIV_BITS-1:63] != '0) begin
                r_res <= r_neg ? S64_MIN : S64_MAX;
            end else begin
                r_res <= signed_sat64(r_dvd[63:0], r_neg);
            end
        end
    end

endmodule
`default_nettype wire

// ===== sv/zeu_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// zeu_back
// Executes queued jobs: zone tables, work sums, the matrix row accumulator,
// the energy update with lumped-mass fallback, and the output register.
// ----------------------------------------------------------------------------
module zeu_back import zeu_pkg::*; #(
    parameter int MAX_ZONES = DEF_MAX_ZONES
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_job_vld,
    input  wire t_job        i_job,
    output logic             o_job_pop,
    input  wire logic [30:0] i_time_step,
    input  wire logic        i_stage_select,
    output logic             o_valid,
    input  wire logic        i_ready,
    output t_out             o_data
);

    localparam int SLOTS = (MAX_ZONES < ZONE_SLOT_LIMIT) ? MAX_ZONES : ZONE_SLOT_LIMIT;
    localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    typedef enum logic [10:0] {
        S_IDLE     = 11'b000_0000_0001,
        S_TERM_MUL = 11'b000_0000_0010,
        S_TERM_ACC = 11'b000_0000_0100,
        S_MX_X     = 11'b000_0000_1000,
        S_MX_WAIT  = 11'b000_0001_0000,
        S_MX_ACC   = 11'b000_0010_0000,
        S_EM_WAIT  = 11'b000_0100_0000,
        S_EM_CHK   = 11'b000_1000_0000,
        S_FB_MUL   = 11'b001_0000_0000,
        S_FB_DIV   = 11'b010_0000_0000,
        S_OUT      = 11'b100_0000_0000
    } t_bstate;

    t_bstate r_state, n_state;

    logic signed [63:0] r_ws_mem [SLOTS];
    logic signed [31:0] r_sh_mem [SLOTS];
    logic signed [31:0] r_ep_mem [SLOTS];
    logic signed [31:0] r_zm_mem [SLOTS];
    logic [SLOTS-1:0]   r_ws_vld;

    logic signed [63:0] r_ws_rd;
    logic signed [31:0] r_sh_rd, r_ep_rd, r_zm_rd;

    logic [5:0]         r_row;
    logic signed [31:0] r_a, r_h, r_v;
    logic               r_last, r_col0, r_fb;
    logic signed [63:0] r_tprod, r_acc, r_e;
    logic               r_o_vld;
    t_out               r_o_data;

    t_in                item;
    logic signed [32:0] sum_ab, sum_cd, sum_bc;
    logic signed [31:0] sh_new;
    logic signed [63:0] sh_ext, ep_ext, ws_src, ws_new, acc_new;
    logic               rd_en;
    logic [AW-1:0]      rd_addr, row_addr;
    logic               out_load;

    t_mul_req           mul_req;
    logic               mul_done;
    logic signed [63:0] mul_res;
    t_div_req           div_req;
    logic               div_done;
    logic signed [63:0] div_res;

    assign item     = i_job.item;
    assign sum_ab   = {item.value_a[31], item.value_a} + {item.value_b[31], item.value_b};
    assign sum_cd   = {item.value_c[31], item.value_c} + {item.value_d[31], item.value_d};
    assign sum_bc   = {item.value_b[31], item.value_b} + {item.value_c[31], item.value_c};
    assign sh_new   = sum_bc[32:1];
    assign sh_ext   = {{32{r_sh_rd[31]}}, r_sh_rd};
    assign ep_ext   = {{32{r_ep_rd[31]}}, r_ep_rd};
    assign ws_src   = sat_add64(r_ws_rd, sh_ext);
    assign ws_new   = sat_add64(r_ws_rd, r_tprod >>> 16);
    assign acc_new  = r_col0 ? mul_res : sat_add64(r_acc, mul_res);
    assign row_addr = r_row[AW-1:0];
    assign out_load = (r_state == S_OUT) && (!r_o_vld || i_ready);
    assign o_valid  = r_o_vld;
    assign o_data   = r_o_data;

    always_comb begin
        n_state       = r_state;
        o_job_pop     = 1'b0;
        rd_en         = 1'b0;
        rd_addr       = row_addr;
        mul_req.start = 1'b0;
        mul_req.x     = r_acc;
        mul_req.m     = {1'b0, i_time_step};
        div_req.start = 1'b0;
        div_req.t     = mul_res;
        div_req.m     = r_zm_rd;
        case (r_state)
            S_IDLE: begin
                if (i_job_vld) begin
                    o_job_pop = 1'b1;
                    case (i_job.kind)
                        KIND_TERM: begin
                            rd_en   = 1'b1;
                            rd_addr = item.row_zone[AW-1:0];
                            n_state = S_TERM_MUL;
                        end
                        KIND_MAT, KIND_MAT_LAST: begin
                            rd_en   = 1'b1;
                            rd_addr = item.col_zone[AW-1:0];
                            n_state = S_MX_X;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_TERM_MUL: n_state = S_TERM_ACC;
            S_TERM_ACC: n_state = S_IDLE;
            S_MX_X: begin
                mul_req.start = 1'b1;
                mul_req.x     = ws_src;
                mul_req.m     = r_a;
                n_state       = S_MX_WAIT;
            end
            S_MX_WAIT: begin
                if (mul_done) begin
                    n_state = r_last ? S_MX_ACC : S_IDLE;
                end
            end
            S_MX_ACC: begin
                mul_req.start = 1'b1;
                rd_en         = 1'b1;
                n_state       = S_EM_WAIT;
            end
            S_EM_WAIT: begin
                if (mul_done) begin
                    n_state = S_EM_CHK;
                end
            end
            S_EM_CHK: begin
                if (r_e > 64'sd0) begin
                    n_state = S_OUT;
                end else begin
                    mul_req.start = 1'b1;
                    mul_req.x     = ws_src;
                    n_state       = S_FB_MUL;
                end
            end
            S_FB_MUL: begin
                if (mul_done) begin
                    div_req.start = 1'b1;
                    n_state       = S_FB_DIV;
                end
            end
            S_FB_DIV: begin
                if (div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ws_vld <= '0;
            r_acc    <= 64'sd0;
            r_o_vld  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_IDLE && i_job_vld && i_job.kind == KIND_CLEAR) begin
                r_ws_vld <= '0;
            end else if (r_state == S_TERM_ACC) begin
                r_ws_vld[row_addr] <= 1'b1;
            end
            if (r_state == S_MX_WAIT && mul_done) begin
                r_acc <= acc_new;
            end else if (r_state == S_MX_ACC) begin
                // The finished row sum has been handed to the multiplier.
                r_acc <= 64'sd0;
            end
            if (out_load) begin
                r_o_vld <= 1'b1;
            end else if (i_ready) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_job_vld) begin
            r_row  <= item.row_zone;
            r_a    <= item.value_a;
            r_h    <= sum_ab[32:1];
            r_v    <= i_stage_select ? sum_cd[32:1] : item.value_c;
            r_last <= (i_job.kind == KIND_MAT_LAST);
            r_col0 <= (item.col_zone == 6'd0);
            if (i_job.kind == KIND_ZONE) begin
                r_ep_mem[item.row_zone[AW-1:0]] <= item.value_a;
                r_sh_mem[item.row_zone[AW-1:0]] <= sh_new;
                r_zm_mem[item.row_zone[AW-1:0]] <= item.value_d;
            end
        end
        if (rd_en) begin
            r_ws_rd <= r_ws_vld[rd_addr] ? r_ws_mem[rd_addr] : 64'sd0;
            r_sh_rd <= r_sh_mem[rd_addr];
            r_ep_rd <= r_ep_mem[rd_addr];
            r_zm_rd <= r_zm_mem[rd_addr];
        end
        if (r_state == S_TERM_MUL) begin
            r_tprod <= 64'(r_h) * 64'(r_v);
        end
        if (r_state == S_TERM_ACC) begin
            r_ws_mem[row_addr] <= ws_new;
        end
        if (r_state == S_EM_WAIT && mul_done) begin
            r_e  <= sat_add64(ep_ext, mul_res);
            r_fb <= 1'b0;
        end else if (r_state == S_FB_DIV && div_done) begin
            r_e  <= sat_add64(ep_ext, div_res);
            r_fb <= 1'b1;
        end
        if (out_load) begin
            r_o_data.zone_index <= r_row;
            r_o_data.new_energy <= sat32(r_e);
            if (!r_fb) begin
                r_o_data.energy_status <= STS_NORMAL;
            end else if (r_e > 64'sd0) begin
                r_o_data.energy_status <= STS_FALLBACK;
            end else begin
                r_o_data.energy_status <= STS_NONPOS;
            end
        end
    end

    zeu_mulq u_mulq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_done  (mul_done),
        .o_res   (mul_res)
    );

    zeu_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_res   (div_res)
    );

endmodule
`default_nettype wire
